>>> rtl/was_pkg.sv
// Shared types and constants for the window assignment scorer.
package was_pkg;

   localparam int MaxRowsDefault   = 64;
   localparam int MaxColsDefault   = 64;
   localparam int MaxWindowDefault = 8;

   localparam logic [1:0] CSR_WINDOW_SIZE = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD   = 2'd1;
   localparam logic [1:0] CSR_ROWS_IN_USE = 2'd2;
   localparam logic [1:0] CSR_COLS_IN_USE = 2'd3;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_EVAL  = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_OUTSIDE = 1'b1;

   typedef struct packed {
      logic               action;
      logic [5:0]         row;
      logic [5:0]         col;
      logic signed [15:0] similarity;
   } req_type;

   typedef struct packed {
      logic [5:0]         window_row;
      logic [5:0]         window_col;
      logic [11:0]        linear_index;
      logic signed [15:0] score;
      logic               below_threshold;
      logic               status;
   } rsp_type;

endpackage

>>> rtl/was_divider.sv
// Restoring divider for the assignment total divided by the window width.
module was_divider #(
   parameter int WinW = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] dividend,
   input  logic [WinW-1:0]    divisor,
   output logic               done,
   output logic signed [31:0] quotient
);

   logic [31:0] mag_ff, mag_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   // One quotient bit per cycle, magnitude only; sign restored at the end.
   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, mag_ff[31]} - {{(33-WinW){1'b0}}, divisor};
      if (start) begin
         neg_in  = dividend[31];
         mag_in  = dividend[31] ? 32'(-dividend) : 32'(dividend);
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         mag_in = {mag_ff[30:0], 1'b0};
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], mag_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign done     = busy_ff && (cnt_ff == 6'd1);
   assign quotient = neg_ff ? -$signed(quo_in) : $signed(quo_in);

endmodule

>>> rtl/window_assignment_score_core.sv
// Top level of the sliding window assignment scorer.
//
//  channel | direction | ports                        | beat
//  req     | in        | req_valid, req_stall, req_data | write cell or evaluate window
//  rsp     | out       | rsp_valid, rsp_stall, rsp_data | one result per evaluate
//  csr     | in        | csr_we, csr_index, csr_wdata   | register write
//
// An evaluate beat on a good window runs a subset dynamic program over 2^k masks; each
// mask-column step passes a read state and an update state in the shared adder and compare,
// as the store and the table have registered reads. The total is then divided by k in the
// serial divider; a window outside the matrix skips the program and the divide.
// Reset is synchronous and clears control and the configuration registers; the store is not cleared.
// Input is refused while an item is in work or its result waits; a stalled result holds.
module window_assignment_score_core #(
   parameter int MaxRows   = was_pkg::MaxRowsDefault,
   parameter int MaxCols   = was_pkg::MaxColsDefault,
   parameter int MaxWindow = was_pkg::MaxWindowDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  was_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output was_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   localparam int Depth  = MaxRows * MaxCols;
   localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int Masks  = 1 << MaxWindow;
   localparam int MaskW  = MaxWindow + 1;
   localparam int KW     = $clog2(MaxWindow + 1);
   localparam int CW     = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
   localparam logic signed [31:0] NegInf = -32'sd1073741824;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_INIT   = 7'b0000010,
      ST_READ   = 7'b0000100,
      ST_UPD    = 7'b0001000,
      ST_DIV    = 7'b0010000,
      ST_DWAIT  = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [3:0]         ksize_ff;
   logic signed [15:0] thr_ff;
   logic [6:0]         rows_ff, cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ksize_ff <= 4'd1;
         thr_ff   <= '0;
         rows_ff  <= 7'd64;
         cols_ff  <= 7'd64;
      end else if (csr_we) begin
         case (csr_index)
            was_pkg::CSR_WINDOW_SIZE: ksize_ff <= csr_wdata[3:0];
            was_pkg::CSR_THRESHOLD:   thr_ff   <= csr_wdata;
            was_pkg::CSR_ROWS_IN_USE: rows_ff  <= csr_wdata[6:0];
            was_pkg::CSR_COLS_IN_USE: cols_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // Loaded sizes limited to the store.
   logic [11:0] rows_lim, cols_lim;
   assign rows_lim = (12'(rows_ff) > 12'(MaxRows)) ? 12'(MaxRows) : 12'(rows_ff);
   assign cols_lim = (12'(cols_ff) > 12'(MaxCols)) ? 12'(MaxCols) : 12'(cols_ff);

   // Similarity store, one write port and one read port.
   logic [15:0] store_mem [Depth];
   logic [15:0] store_q_ff;
   logic        store_we;
   logic [AddrW-1:0] store_wa, store_ra;

   always_ff @(posedge clock) begin
      if (store_we) store_mem[store_wa] <= req_data.similarity;
      store_q_ff <= store_mem[store_ra];
   end

   // DP table of best totals per column subset.
   logic signed [31:0] best_mem [Masks];
   logic signed [31:0] best_q_ff, dst_q_ff;
   logic               best_we;
   logic [MaxWindow-1:0] best_wa, best_ra, dst_ra;
   logic signed [31:0] best_wd;

   always_ff @(posedge clock) begin
      if (best_we) best_mem[best_wa] <= best_wd;
      best_q_ff <= best_mem[best_ra];
      dst_q_ff  <= best_mem[dst_ra];
   end

   // Item registers.
   logic [5:0]          row_ff, col_ff;
   logic [KW-1:0]       k_ff;
   logic [MaskW-1:0]    mask_ff, mask_in;
   logic [CW:0]         c_ff, c_in;
   logic [KW-1:0]       pop_ff, pop_in;
   logic                bad_ff;
   was_pkg::rsp_type    out_ff, out_in;
   logic                outv_ff;

   logic [MaskW-1:0] full;
   assign full = MaskW'((MaskW'(1) << k_ff) - MaskW'(1));

   logic accept;
   assign req_stall = (state_ff != ST_IDLE) || outv_ff;
   assign accept    = req_valid && !req_stall;

   // Window check.
   logic        win_bad;
   always_comb begin
      win_bad = (ksize_ff == 4'd0) || (32'(ksize_ff) > MaxWindow)
             || (12'(req_data.row) + 12'(ksize_ff) > rows_lim)
             || (12'(req_data.col) + 12'(ksize_ff) > cols_lim);
   end

   // Store write enable, write address and read address.
   assign store_we = accept && (req_data.action == was_pkg::ACTION_WRITE)
                  && (32'(req_data.row) < MaxRows) && (32'(req_data.col) < MaxCols);
   assign store_wa = AddrW'(32'(req_data.row) * MaxCols + 32'(req_data.col));
   assign store_ra = AddrW'((32'(row_ff) + 32'(pop_ff)) * MaxCols
                          + 32'(col_ff) + 32'(c_ff[CW-1:0]));

   logic bit_set;
   assign bit_set = mask_ff[c_ff[CW-1:0]];
   logic [MaxWindow-1:0] dst_mask;
   assign dst_mask = mask_ff[MaxWindow-1:0] | (MaxWindow'(1) << c_ff[CW-1:0]);
   assign best_ra = mask_ff[MaxWindow-1:0];
   assign dst_ra  = dst_mask;

   // Divider.
   logic               div_start, div_done;
   logic signed [31:0] div_q;
   was_divider #(.WinW(KW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(best_q_ff), .divisor(k_ff), .done(div_done), .quotient(div_q)
   );

   logic signed [31:0] cand;
   assign cand = best_q_ff + 32'(signed'(store_q_ff));

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      mask_in   = mask_ff;
      c_in      = c_ff;
      pop_in    = pop_ff;
      out_in    = out_ff;
      best_we   = 1'b0;
      best_wa   = mask_ff[MaxWindow-1:0];
      best_wd   = NegInf;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.action == was_pkg::ACTION_EVAL) begin
               mask_in = '0;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            best_we = 1'b1;
            best_wd = (mask_ff == '0) ? 32'sd0 : NegInf;
            if (bad_ff) begin
               state_in = ST_OUT;
            end else if (mask_ff == full) begin
               mask_in = '0;
               c_in    = '0;
               pop_in  = '0;
               state_in = ST_READ;
            end else begin
               mask_in = mask_ff + MaskW'(1);
            end
         end
         ST_READ: begin
            // Memories fetch best[mask], best[dst] and the cell.
            if (mask_ff == full) begin
               state_in = ST_DIV;
            end else if (c_ff == (CW+1)'(k_ff)) begin
               c_in    = '0;
               mask_in = mask_ff + MaskW'(1);
               pop_in  = KW'($countones(mask_ff + MaskW'(1)));
            end else begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (!bit_set && best_q_ff != NegInf && cand > dst_q_ff) begin
               best_we = 1'b1;
               best_wa = dst_mask;
               best_wd = cand;
            end
            c_in = c_ff + (CW+1)'(1);
            state_in = ST_READ;
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_done) begin
               out_in.linear_index = 12'(32'(row_ff) + 32'(col_ff)
                                   * (32'(rows_lim) - 32'(k_ff) + 1));
               if (div_q >= 32'(thr_ff)) begin
                  out_in.score = div_q[15:0];
                  out_in.below_threshold = 1'b0;
               end else begin
                  out_in.score = '0;
                  out_in.below_threshold = 1'b1;
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (accept) begin
         out_in.window_row = req_data.row;
         out_in.window_col = req_data.col;
         out_in.linear_index = '0;
         out_in.score = '0;
         out_in.below_threshold = 1'b0;
         out_in.status = win_bad ? was_pkg::STATUS_OUTSIDE : was_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      c_ff    <= c_in;
      pop_ff  <= pop_in;
      out_ff  <= out_in;
      if (accept) begin
         row_ff <= req_data.row;
         col_ff <= req_data.col;
         k_ff   <= KW'(ksize_ff);
         bad_ff <= win_bad;
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT) outv_ff <= 1'b1;
         else if (outv_ff && !rsp_stall) outv_ff <= 1'b0;
      end
   end

   assign rsp_valid = outv_ff;
   assign rsp_data  = out_ff;

endmodule

>>> bench/tb_window_assignment_score_core.sv
// Self-checking testbench for the sliding window assignment scorer.
`timescale 1ns / 100ps

module tb_window_assignment_score_core;

   localparam int LimitCycles = 15000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   was_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   was_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = was_pkg::CSR_WINDOW_SIZE;
   logic [15:0]      csr_wdata = '0;

   // Register copies, the cell store and the generation-side record of written cells.
   logic [3:0]         win_k = 4'd1;
   logic signed [15:0] min_score = '0;
   logic [6:0]         rows_loaded = 7'd64;
   logic [6:0]         cols_loaded = 7'd64;
   logic [15:0]        cell_mem [64][64];
   bit                 cell_known [64][64];

   was_pkg::req_type pending_beats [$];
   was_pkg::rsp_type score_due [$];
   bit      failed = 1'b0;
   int      cycle_count = 0;
   int      items_queued = 0;

   window_assignment_score_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Random idling, with a stretch at the start of every period in which it never idles.
   function automatic bit take_break();
      if ((cycle_count % 20000) < 5000) return 1'b0;
      return $urandom_range(99) < 18;
   endfunction

   function automatic bit window_fails(logic [5:0] r, logic [5:0] c);
      int rows_eff;
      int cols_eff;
      rows_eff = (rows_loaded > 64) ? 64 : rows_loaded;
      cols_eff = (cols_loaded > 64) ? 64 : cols_loaded;
      return (win_k == 0) || (win_k > 8) || (r + win_k > rows_eff) || (c + win_k > cols_eff);
   endfunction

   // Best one-to-one assignment total over the window, averaged and thresholded.
   function automatic was_pkg::rsp_type window_score(logic [5:0] r, logic [5:0] c);
      was_pkg::rsp_type res;
      int best [256];
      int full;
      int ones;
      int total;
      int q;
      int v;
      int rows_eff;
      res = '0;
      res.window_row = r;
      res.window_col = c;
      if (window_fails(r, c)) begin
         res.status = was_pkg::STATUS_OUTSIDE;
         return res;
      end
      rows_eff = (rows_loaded > 64) ? 64 : rows_loaded;
      full = (1 << win_k) - 1;
      for (int m = 0; m <= full; m++) best[m] = -1073741824;
      best[0] = 0;
      for (int m = 0; m < full; m++) begin
         if (best[m] == -1073741824) continue;
         ones = $countones(m);
         for (int j = 0; j < win_k; j++) begin
            if (m & (1 << j)) continue;
            v = best[m] + int'($signed(cell_mem[r + ones][c + j]));
            if (v > best[m | (1 << j)]) best[m | (1 << j)] = v;
         end
      end
      total = best[full];
      q = total / int'(win_k);
      res.status = was_pkg::STATUS_OK;
      res.linear_index = 12'(r + c * (rows_eff - win_k + 1));
      if (q >= int'(min_score)) res.score = 16'(q);
      else res.below_threshold = 1'b1;
      return res;
   endfunction

   // Driver: a new beat is presented only once the current one is taken.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_data.action == was_pkg::ACTION_WRITE)
               cell_mem[req_data.row][req_data.col] = req_data.similarity;
            else
               score_due.insert(score_due.size(), window_score(req_data.row, req_data.col));
         end
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() > 0 && !take_break()) begin
               req_data <= pending_beats.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each result beat with the oldest expected score.
   always @(posedge clock) begin
      was_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (score_due.size() == 0) begin
               $error("unexpected result beat %h", rsp_data);
               failed = 1'b1;
            end else begin
               want = score_due.pop_front();
               if (rsp_data.window_row !== want.window_row) begin
                  $error("window_row: expected %0d, got %0d", want.window_row,
                         rsp_data.window_row);
                  failed = 1'b1;
               end
               if (rsp_data.window_col !== want.window_col) begin
                  $error("window_col: expected %0d, got %0d", want.window_col,
                         rsp_data.window_col);
                  failed = 1'b1;
               end
               if (rsp_data.linear_index !== want.linear_index) begin
                  $error("linear_index: expected %0d, got %0d", want.linear_index,
                         rsp_data.linear_index);
                  failed = 1'b1;
               end
               if (rsp_data.score !== want.score) begin
                  $error("score: expected %0d, got %0d", want.score, rsp_data.score);
                  failed = 1'b1;
               end
               if (rsp_data.below_threshold !== want.below_threshold) begin
                  $error("below_threshold: expected %0b, got %0b", want.below_threshold,
                         rsp_data.below_threshold);
                  failed = 1'b1;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0b, got %0b", want.status, rsp_data.status);
                  failed = 1'b1;
               end
            end
         end
         rsp_stall <= take_break();
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (cycle_count > LimitCycles) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic queue_cell(logic [5:0] r, logic [5:0] c, logic [15:0] value);
      was_pkg::req_type beat;
      beat = '0;
      beat.action = was_pkg::ACTION_WRITE;
      beat.row = r;
      beat.col = c;
      beat.similarity = value;
      pending_beats.insert(pending_beats.size(), beat);
      cell_known[r][c] = 1'b1;
      items_queued++;
   endtask

   // Queues an evaluate beat, first loading any cell of the window not yet written.
   task automatic queue_window(logic [5:0] r, logic [5:0] c);
      was_pkg::req_type beat;
      if (!window_fails(r, c)) begin
         for (int i = 0; i < win_k; i++)
            for (int j = 0; j < win_k; j++)
               if (!cell_known[r + i][c + j]) queue_cell(6'(r + i), 6'(c + j), 16'($urandom));
      end
      beat = '0;
      beat.action = was_pkg::ACTION_EVAL;
      beat.row = r;
      beat.col = c;
      beat.similarity = 16'($urandom);
      pending_beats.insert(pending_beats.size(), beat);
      items_queued++;
   endtask

   task automatic set_reg(logic [1:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         was_pkg::CSR_WINDOW_SIZE: win_k = value[3:0];
         was_pkg::CSR_THRESHOLD:   min_score = value;
         was_pkg::CSR_ROWS_IN_USE: rows_loaded = value[6:0];
         default:                  cols_loaded = value[6:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      while (pending_beats.size() != 0 || req_valid || score_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_all(logic [3:0] k, logic [15:0] thr, logic [6:0] rr, logic [6:0] cc);
      set_reg(was_pkg::CSR_WINDOW_SIZE, 16'(k));
      set_reg(was_pkg::CSR_THRESHOLD, thr);
      set_reg(was_pkg::CSR_ROWS_IN_USE, 16'(rr));
      set_reg(was_pkg::CSR_COLS_IN_USE, 16'(cc));
   endtask

   initial begin
      logic [3:0] k;
      logic [6:0] rr;
      logic [6:0] cc;
      int rows_eff;
      int cols_eff;
      int n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, extreme cell values and corners.
      queue_cell(6'd0, 6'd0, 16'sd16384);
      queue_cell(6'd63, 6'd63, -16'sd16384);
      queue_cell(6'd0, 6'd63, 16'h7fff);
      queue_cell(6'd63, 6'd0, 16'h8000);
      queue_window(6'd0, 6'd0);
      queue_window(6'd63, 6'd63);
      queue_window(6'd0, 6'd63);
      queue_window(6'd63, 6'd0);
      settle();

      // Largest window at the far corner, one just outside, and a high threshold.
      set_all(4'd8, 16'hc000, 7'd64, 7'd64);
      queue_window(6'd56, 6'd56);
      queue_window(6'd57, 6'd0);
      settle();
      set_all(4'd2, 16'sd16384, 7'd127, 7'd3);
      queue_window(6'd0, 6'd0);
      queue_window(6'd0, 6'd2);
      settle();

      // Bad window sizes and an empty loaded matrix.
      set_all(4'd0, 16'h0000, 7'd64, 7'd64);
      queue_window(6'd0, 6'd0);
      settle();
      set_all(4'd15, 16'hffff, 7'd0, 7'd64);
      queue_window(6'd0, 6'd0);
      settle();
      set_reg(was_pkg::CSR_WINDOW_SIZE, 16'd9);
      queue_window(6'd1, 6'd1);
      settle();
      set_reg(was_pkg::CSR_WINDOW_SIZE, 16'd1);
      queue_window(6'd0, 6'd0);
      settle();

      // Random phases with fresh register settings.
      while (items_queued < 400) begin
         n = $urandom_range(99);
         if (n < 5) k = 4'($urandom_range(15));
         else if (n < 15) k = 4'($urandom_range(8, 5));
         else k = 4'($urandom_range(4, 1));
         n = $urandom_range(99);
         rr = (n < 5) ? 7'($urandom_range(127)) : 7'($urandom_range(64, 1));
         cc = (n > 94) ? 7'($urandom_range(127)) : 7'($urandom_range(64, 1));
         set_all(k, 16'($urandom_range(32768) - 16384), rr, cc);
         rows_eff = (rows_loaded > 64) ? 64 : rows_loaded;
         cols_eff = (cols_loaded > 64) ? 64 : cols_loaded;
         for (int i = 0; i < 30 && items_queued < 400; i++) begin
            n = $urandom_range(99);
            if (n < 35) begin
               queue_cell(6'($urandom), 6'($urandom), 16'($urandom));
            end else if (n < 90 && win_k >= 1 && win_k <= 8 && rows_eff >= win_k &&
                         cols_eff >= win_k) begin
               queue_window(6'($urandom_range(rows_eff - win_k)),
                            6'($urandom_range(cols_eff - win_k)));
            end else begin
               queue_window(6'($urandom), 6'($urandom));
            end
         end
         settle();
      end

      settle();
      repeat (100) @(posedge clock);
      if (!failed && score_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
